// ===== rtl/antialiased_disc_alpha_macros.svh =====
// Assertion macros for the bound checker adp_checker.
`ifndef ANTIALIASED_DISC_ALPHA_MACROS_SVH
`define ANTIALIASED_DISC_ALPHA_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ADP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("adp: property violated");

// Check that the antecedent implies the consequent at the same edge.
`define ADP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adp: implication violated");

// Check that the antecedent implies the consequent one pipeline latency later.
`define ADP_ASSERT_LAT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##ADP_LATENCY (cons)) \
        else $error("adp: latency violated");

`endif

// ===== rtl/adp_pkg.sv =====
package adp_pkg;

    localparam int COORD_W      = 12;
    localparam int SIZE_W       = 13;
    localparam int RAD_W        = 12;
    localparam int SQ_W         = 2 * RAD_W;
    localparam int Q_W          = SQ_W + 1;
    localparam int Q_IN_W       = 2 * (RAD_W - 1) + 1;
    localparam int FRAC_W       = 8;
    localparam int REM_W        = Q_IN_W + 2 * FRAC_W;
    localparam int ROOT_W       = RAD_W + FRAC_W;
    localparam int OFS_W        = 26;
    localparam int ALPHA_W      = 8;

    localparam int MAX_SIZE     = 4096;
    localparam int EDGE_WIDTH   = 64;
    localparam int EDGE_SHIFT   = $clog2(EDGE_WIDTH * (1 << FRAC_W));

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    localparam int FRONT_STAGES = 3;
    localparam int ADP_LATENCY  = FRONT_STAGES + ROOT_W + 1;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pix_in_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [OFS_W-1:0]   byte_offset;
    } pix_out_t;

    typedef struct packed {
        logic               in_disc;
        logic [ROOT_W-1:0]  root;
        logic [REM_W-1:0]   rem;
        logic [RAD_W-1:0]   radius;
        logic [OFS_W-1:0]   offset;
    } sq_t;

endpackage

// ===== rtl/antialiased_disc_alpha.sv =====
// Antialiased disc alpha generator.
// Input: pixel word (pixel_x, pixel_y), taken on a rising edge with start high
// and busy low. One word may be taken on every clock; busy is high only while
// reset is applied and for the first edge after its release.
// Output: one result word (alpha, byte_offset) per input word, in input order,
// shown for one cycle with done high. The receiver cannot stall, so the
// pipeline always advances and never needs to hold a word back.
// Pipeline: the accepting edge registers the word into the first of 3 front
// stages (clamp and distance, squares and row product, sum and compare), then
// one stage per bit of the 20-bit square root, and one output stage;
// throughput one pixel per clock.
// Configuration: cfg_we writes cfg_wdata to sprite_size; write it only while
// no pixel is in flight. Reset sets sprite_size to 256 and empties the
// pipeline; no result is produced until a new pixel is accepted.
module antialiased_disc_alpha
    import adp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pix_in_t           pixel,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    output logic              done,
    output pix_out_t          result
);

    logic busy_reg;
    logic accept;
    logic f_valid;
    sq_t  f_word;
    logic s_valid;
    sq_t  s_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    adp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (accept),
        .pix       (pixel),
        .out_valid (f_valid),
        .out_word  (f_word)
    );

    adp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_word   (f_word),
        .out_valid (s_valid),
        .out_word  (s_word)
    );

    adp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_valid),
        .in_word  (s_word),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== rtl/adp_front.sv =====
module adp_front
    import adp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_wdata,
    input  logic               in_valid,
    input  pix_in_t            pix,
    output logic               out_valid,
    output sq_t                out_word
);

    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  side;
    logic [RAD_W-1:0]   rad;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;

    logic               v1_reg;
    logic [SIZE_W-1:0]  s1_reg;
    logic [RAD_W-1:0]   r1_reg;
    logic [COORD_W-1:0] x1_reg;
    logic [COORD_W-1:0] y1_reg;
    logic [COORD_W-1:0] adx1_reg;
    logic [COORD_W-1:0] ady1_reg;

    logic               v2_reg;
    logic [SQ_W-1:0]    sqx2_reg;
    logic [SQ_W-1:0]    sqy2_reg;
    logic [SQ_W-1:0]    rr2_reg;
    logic [Q_W-1:0]     ys2_reg;
    logic [COORD_W-1:0] x2_reg;
    logic [RAD_W-1:0]   r2_reg;

    logic [Q_W-1:0]     q_sum;
    logic [Q_W-1:0]     ofs_sum;
    logic               in_disc;
    logic               v3_reg;
    sq_t                w3_reg;
    sq_t                w3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            side = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(MAX_SIZE))
        begin
            side = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            side = size_reg;
        end
        rad = side[SIZE_W-1:1];
        adx = (pix.pixel_x >= rad) ? pix.pixel_x - rad : rad - pix.pixel_x;
        ady = (pix.pixel_y >= rad) ? pix.pixel_y - rad : rad - pix.pixel_y;
    end

    always_comb
    begin
        q_sum   = Q_W'(sqx2_reg) + Q_W'(sqy2_reg);
        ofs_sum = ys2_reg + Q_W'(x2_reg);
        in_disc = (q_sum <= Q_W'(rr2_reg));
        w3_next.in_disc = in_disc;
        w3_next.root    = '0;
        w3_next.rem     = in_disc ? {q_sum[Q_IN_W-1:0], {(2*FRAC_W){1'b0}}} : '0;
        w3_next.radius  = r2_reg;
        w3_next.offset  = {ofs_sum[OFS_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= side;
        r1_reg   <= rad;
        x1_reg   <= pix.pixel_x;
        y1_reg   <= pix.pixel_y;
        adx1_reg <= adx;
        ady1_reg <= ady;

        sqx2_reg <= SQ_W'(adx1_reg) * SQ_W'(adx1_reg);
        sqy2_reg <= SQ_W'(ady1_reg) * SQ_W'(ady1_reg);
        rr2_reg  <= SQ_W'(r1_reg) * SQ_W'(r1_reg);
        ys2_reg  <= Q_W'(y1_reg) * Q_W'(s1_reg);
        x2_reg   <= x1_reg;
        r2_reg   <= r1_reg;

        w3_reg   <= w3_next;
    end

    assign out_valid = v3_reg;
    assign out_word  = w3_reg;

endmodule

// ===== rtl/adp_sqrt.sv =====
module adp_sqrt
    import adp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sq_t  in_word,
    output logic out_valid,
    output sq_t  out_word
);

    localparam int TRIAL_W = REM_W + 1;

    logic [ROOT_W-1:0] vld_reg;
    sq_t               stage_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_bit
        localparam int B = ROOT_W - 1 - g;

        logic               cur_valid;
        sq_t                cur;
        sq_t                stage_next;
        logic [TRIAL_W-1:0] trial;
        logic               take;

        if (g == 0)
        begin : g_first
            assign cur_valid = in_valid;
            assign cur       = in_word;
        end
        else
        begin : g_rest
            assign cur_valid = vld_reg[g-1];
            assign cur       = stage_reg[g-1];
        end

        always_comb
        begin
            trial = (TRIAL_W'(cur.root) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
            take  = ({1'b0, cur.rem} >= trial);
            stage_next = cur;
            if (take)
            begin
                stage_next.root = cur.root | (ROOT_W'(1) << B);
                stage_next.rem  = cur.rem - trial[REM_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[g] <= stage_next;
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_word  = stage_reg[ROOT_W-1];

endmodule

// ===== rtl/adp_back.sv =====
module adp_back
    import adp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  sq_t      in_word,
    output logic     done,
    output pix_out_t result
);

    localparam int PROD_W = ROOT_W + 8;
    localparam int A_W    = PROD_W - EDGE_SHIFT;

    logic [ROOT_W-1:0] diff;
    logic [PROD_W-1:0] prod;
    logic [A_W-1:0]    scaled;
    pix_out_t          result_next;
    pix_out_t          result_reg;
    logic              done_reg;

    always_comb
    begin
        diff   = {in_word.radius, {FRAC_W{1'b0}}} - in_word.root;
        prod   = {diff, 8'b0} - PROD_W'(diff);
        scaled = prod[PROD_W-1:EDGE_SHIFT];
        if (!in_word.in_disc)
        begin
            result_next.alpha = '0;
        end
        else if (|scaled[A_W-1:ALPHA_W])
        begin
            result_next.alpha = '1;
        end
        else
        begin
            result_next.alpha = scaled[ALPHA_W-1:0];
        end
        result_next.byte_offset = in_word.offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/adp_checker.sv =====
`include "antialiased_disc_alpha_macros.svh"

module adp_checker
    import adp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input pix_in_t           pixel,
    input logic              cfg_we,
    input logic [SIZE_W-1:0] cfg_wdata,
    input logic              done,
    input pix_out_t          result
);

    `ADP_ASSERT_LAT(a_word_returns, start && !busy, done)
    `ADP_ASSERT_IMP(a_no_stray_result, done, $past(start && !busy, ADP_LATENCY))
    `ADP_ASSERT_IMP(a_ready_after_reset, $past(rst_n), !busy)
    `ADP_ASSERT_IMP(a_offset_aligned, done, result.byte_offset[1:0] == 2'b00)

endmodule

bind antialiased_disc_alpha adp_checker u_adp_checker (.*);

// ===== dv/disc_alpha_checker.sv =====
`timescale 1ns / 100ps

module disc_alpha_checker
    import adp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  pix_in_t           pixel,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              done,
    input  pix_out_t          result,
    output int                words_due,
    output int                mismatches,
    output int                pixels_checked,
    output int                fade_hits
);

    logic [SIZE_W-1:0] sprite_side;
    pix_out_t          shade_due[$];

    function automatic pix_out_t disc_pixel(input pix_in_t p, input logic [SIZE_W-1:0] size_reg);
        logic [63:0] side;
        logic [63:0] rad;
        logic [63:0] xs;
        logic [63:0] ys;
        logic [63:0] adx;
        logic [63:0] ady;
        logic [63:0] dsq;
        logic [63:0] scaled;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] shade;
        pix_out_t    o;
        if (size_reg == '0)
            side = 64'd1;
        else if (size_reg > MAX_SIZE)
            side = 64'(MAX_SIZE);
        else
            side = 64'(size_reg);
        rad = side >> 1;
        xs  = 64'(p.pixel_x);
        ys  = 64'(p.pixel_y);
        adx = (xs >= rad) ? xs - rad : rad - xs;
        ady = (ys >= rad) ? ys - rad : rad - ys;
        dsq = adx * adx + ady * ady;
        o.alpha = '0;
        if (dsq <= rad * rad)
        begin
            // settle the Q.8 root one bit at a time, top bit first
            scaled = dsq << (2 * FRAC_W);
            root   = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= scaled)
                    root = trial;
            end
            shade = (64'd255 * ((rad << FRAC_W) - root)) / (EDGE_WIDTH * (1 << FRAC_W));
            o.alpha = (shade > 64'd255) ? 8'hFF : shade[ALPHA_W-1:0];
        end
        o.byte_offset = OFS_W'((ys * side + xs) * 64'd4);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pix_out_t want;
        if (!rst_n)
        begin
            sprite_side    <= SIZE_RESET;
            shade_due.delete();
            words_due      <= 0;
            mismatches     <= 0;
            pixels_checked <= 0;
            fade_hits      <= 0;
        end
        else
        begin
            if (done)
            begin
                if (shade_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result word with none due: alpha %0d offset %0d",
                                 $time, result.alpha, result.byte_offset);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = shade_due.pop_front();
                    if (result.alpha !== want.alpha || result.byte_offset !== want.byte_offset)
                    begin
                        if (mismatches < 10)
                            $display("%0t: alpha %0d/%0d offset %0d/%0d (expected/actual)",
                                     $time, want.alpha, result.alpha,
                                     want.byte_offset, result.byte_offset);
                        mismatches <= mismatches + 1;
                    end
                    pixels_checked <= pixels_checked + 1;
                    if (want.alpha != 8'h00 && want.alpha != 8'hFF)
                        fade_hits <= fade_hits + 1;
                end
            end
            if (start && !busy)
                shade_due.push_back(disc_pixel(pixel, sprite_side));
            if (cfg_we)
                sprite_side <= cfg_wdata;
            words_due <= shade_due.size();
        end
    end

endmodule

// ===== dv/tb_antialiased_disc_alpha.sv =====
`timescale 1ns / 100ps

module tb_antialiased_disc_alpha;
    import adp_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SWEEPS      = 12;
    localparam int SWEEP_WORDS = 66;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    pix_in_t           pixel;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    logic              done;
    pix_out_t          result;

    int                words_due;
    int                mismatches;
    int                pixels_checked;
    int                fade_hits;
    int                idle_pct;
    int                size_writes;
    int                stall_cycles;
    logic [SIZE_W-1:0] sweep_sizes[SWEEPS];

    antialiased_disc_alpha dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    disc_alpha_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pixel          (pixel),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .result         (result),
        .words_due      (words_due),
        .mismatches     (mismatches),
        .pixels_checked (pixels_checked),
        .fade_hits      (fade_hits)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("antialiased_disc_alpha regression: fail");
                $finish;
            end
        end
    end

    task automatic send_pixel(input int x, input int y);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= '{pixel_x: COORD_W'(x > 4095 ? 4095 : x), pixel_y: COORD_W'(y > 4095 ? 4095 : y)};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_words();
        start <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_writes++;
    endtask

    task automatic sweep_sprite(input logic [SIZE_W-1:0] size_val, input int count, input int pct);
        int side;
        int rad;
        int dx;
        int dy;
        int rim;
        int px;
        int py;
        drain_words();
        write_size(size_val);
        if (size_val == '0)
            side = 1;
        else if (size_val > MAX_SIZE)
            side = MAX_SIZE;
        else
            side = int'(size_val);
        rad = side / 2;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    px = $urandom_range(4095);
                    py = $urandom_range(4095);
                end
                1, 2, 3:
                begin
                    // land near the rim so the fade gets exercised
                    dx  = $urandom_range(rad);
                    rim = int'($sqrt(real'(rad * rad - dx * dx)));
                    dy  = rim + 2 - int'($urandom_range(EDGE_WIDTH + 6));
                    if (dy < 0)
                        dy = 0;
                    px = $urandom_range(1) ? rad + dx : rad - dx;
                    py = $urandom_range(1) ? rad + dy : rad - dy;
                    if (py < 0)
                        py = 0;
                    if ($urandom_range(1))
                    begin
                        rim = px;
                        px  = py;
                        py  = rim;
                    end
                end
                default:
                begin
                    px = $urandom_range(side - 1);
                    py = $urandom_range(side - 1);
                end
            endcase
            send_pixel(px, py);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        pixel        = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        idle_pct     = 31;
        size_writes  = 0;
        sweep_sizes  = '{13'd4096, 13'd37, 13'd8191, 13'd1, 13'd2, 13'd3,
                         13'd256, 13'd4097, 13'd129, 13'd0, 13'd0, 13'd0};
        sweep_sizes[10] = SIZE_W'($urandom_range(1, MAX_SIZE));
        sweep_sizes[11] = SIZE_W'($urandom_range(4, 64));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset size 256: corners, center, rim, fade edge, off-sprite
        send_pixel(0, 0);
        send_pixel(128, 128);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(128, 0);
        send_pixel(0, 128);
        send_pixel(255, 128);
        send_pixel(128, 192);
        send_pixel(128, 193);
        send_pixel(256, 128);
        send_pixel(128, 100);
        send_pixel(200, 200);
        send_pixel(2730, 1365);

        drain_words();
        write_size('0);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(4095, 4095);

        drain_words();
        write_size('1);
        send_pixel(2048, 2048);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 1984);
        send_pixel(4095, 2048);

        for (int k = 0; k < SWEEPS; k++)
            sweep_sprite(sweep_sizes[k], SWEEP_WORDS, (k < 4) ? 31 : (k < 8) ? 57 : 0);

        drain_words();
        repeat (ADP_LATENCY + 8) @(posedge clk);

        $display("%0d pixel words compared over %0d sprite size settings", pixels_checked,
                 size_writes);
        $display("%0d of them fell in the rim fade, %0d mismatches", fade_hits, mismatches);
        if (mismatches == 0)
            $display("antialiased_disc_alpha regression: pass");
        else
            $display("antialiased_disc_alpha regression: fail");
        $finish;
    end

endmodule
